### hdl/hight_block_decrypt_unit_defines.svh
// assertion macros for the hight block decrypt unit
// no dependencies; taken in by the top level, which checks its own logic
`ifndef HIGHT_BLOCK_DECRYPT_UNIT_DEFINES_SVH
`define HIGHT_BLOCK_DECRYPT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define HBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/hbd_pkg.sv
// shared types, constants and round functions of the hight block decrypt unit
// no dependencies; imported by every module of the block but hbd_ram
package hbd_pkg;

  // command codes of the input word
  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // round-key table: 136 bytes kept as 34 rows of four byte banks
  localparam int KEY_DEPTH = 136;
  localparam int BANKS     = 4;
  localparam int BANK_W    = $clog2(BANKS);
  localparam int ROWS      = KEY_DEPTH / BANKS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ROUNDS    = 32;

  // row of the initial whitening keys, of the final ones, of the last round
  localparam logic [ROW_W-1:0] ROW_INIT  = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_FINAL = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // 64-bit block, byte 0 in bits 7:0
  typedef logic [7:0][7:0] block_t;

  // one classified word waiting for the back end
  typedef struct packed {
    logic               dec;
    logic [ROW_W-1:0]   row;
    logic [BANK_W-1:0]  bank;
    logic [7:0]         kbyte;
    block_t             text;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // back-end status
  typedef struct packed {
    logic busy;
    logic last;
  } core_stat_t;

  function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
    rol8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] hight_f0(input logic [7:0] x);
    hight_f0 = rol8(x, 1) ^ rol8(x, 2) ^ rol8(x, 7);
  endfunction

  function automatic logic [7:0] hight_f1(input logic [7:0] x);
    hight_f1 = rol8(x, 3) ^ rol8(x, 4) ^ rol8(x, 6);
  endfunction

endpackage

### hdl/hight_block_decrypt_unit.sv
// top level of the hight 64/128 block decrypt unit
// depends on hbd_pkg, hbd_front, hbd_queue, hbd_core and the defines header
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | command, key_index, key_byte, ciphertext
//  out_    | output    | out_valid/out_stall| plaintext
//
// a key write leaves the queue and is written to its bank; a decrypt steps
// through leaving the queue, final whitening, 32 rounds on the single round unit
// and initial whitening, paced by the key banks giving one four-byte row per cycle.
// reset clears control only; the key table holds nothing defined until written.
// out_stall holds the result in the output register and the back end waits on
// its last step; the front register and a two-word queue keep taking input until full.
`include "hight_block_decrypt_unit_defines.svh"

module hight_block_decrypt_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_key_index,
  input  logic [7:0]  in_key_byte,
  input  logic [63:0] in_ciphertext,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_plaintext
);
  import hbd_pkg::*;

  logic       fr_push;
  item_t      fr_item;
  q_stat_t    q_stat;
  item_t      q_item;
  logic       q_pop;
  core_stat_t core_stat;

  // accept and classify
  hbd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_key_index (in_key_index),
    .in_key_byte  (in_key_byte),
    .in_ciphertext(in_ciphertext),
    .q_stat       (q_stat),
    .q_push       (fr_push),
    .q_item       (fr_item)
  );

  // in-order queue
  hbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .push_item(fr_item),
    .pop      (q_pop),
    .q_stat   (q_stat),
    .q_item   (q_item)
  );

  // key table and decryption
  hbd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_plaintext(out_plaintext),
    .core_stat    (core_stat)
  );

  // checks
  `HBD_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop,
                   q_stat.not_empty && !core_stat.busy, "pop from empty queue or busy back end")
  `HBD_ASSERT_NEXT(a_push_lands, clk, rst_n, fr_push, q_stat.not_empty,
                   "pushed word missing from queue")
  `HBD_ASSERT_NEXT(a_out_from_last, clk, rst_n, !out_valid,
                   !out_valid || $past(core_stat.last), "result without final step")

endmodule

### hdl/hbd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/hbd_front.sv
// front end: takes input words, drops out-of-range key writes, stages the rest
// depends on hbd_pkg
module hbd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [7:0]       in_key_index,
  input  logic [7:0]       in_key_byte,
  input  logic [63:0]      in_ciphertext,
  input  hbd_pkg::q_stat_t q_stat,
  output logic             q_push,
  output hbd_pkg::item_t   q_item
);
  import hbd_pkg::*;

  logic  fr_valid_r, fr_valid_nxt;
  item_t fr_item_r, fr_item_nxt;
  logic  accept, keep;

  // handshake: stall only while the staged word cannot move on
  assign in_stall = fr_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_stat.full;
  assign q_item   = fr_item_r;

  // classify: decrypts always go on, key writes only inside the table
  assign keep = (in_command == CMD_DEC) || (in_key_index < 8'(KEY_DEPTH));

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (q_push) begin
      fr_valid_nxt = 1'b0;
    end
    if (accept && keep) begin
      fr_valid_nxt      = 1'b1;
      fr_item_nxt.dec   = (in_command == CMD_DEC);
      fr_item_nxt.row   = in_key_index[7:BANK_W];
      fr_item_nxt.bank  = in_key_index[BANK_W-1:0];
      fr_item_nxt.kbyte = in_key_byte;
      fr_item_nxt.text  = in_ciphertext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

endmodule

### hdl/hbd_queue.sv
// short in-order queue of classified words between front and back
// depends on hbd_pkg
module hbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hbd_pkg::item_t    push_item,
  input  logic              pop,
  output hbd_pkg::q_stat_t  q_stat,
  output hbd_pkg::item_t    q_item
);
  import hbd_pkg::*;

  item_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.full      = (cnt_r == QCNT_W'(QDEPTH));
  assign q_item           = ent_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/hbd_core.sv
// back end: round-key banks, one shared inverse round, output register
// depends on hbd_pkg and hbd_ram
module hbd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  hbd_pkg::q_stat_t    q_stat,
  input  hbd_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_plaintext,
  output hbd_pkg::core_stat_t core_stat
);
  import hbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WF   = 2'd1;
  localparam logic [1:0] S_RND  = 2'd2;
  localparam logic [1:0] S_WI   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [ROW_W-1:0]       rnd_r, rnd_nxt;
  block_t                 blk_r, blk_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [63:0]            out_pt_r, out_pt_nxt;
  logic [ROW_W-1:0]       raddr;
  logic [BANKS-1:0]       we_bank;
  logic [BANKS-1:0][7:0]  rk;
  block_t                 wf_blk, rnd_blk, wi_blk;

  // four byte banks, one row of four key bytes read per cycle
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    assign we_bank[b] = q_pop && !q_item.dec && (q_item.bank == BANK_W'(b));
    hbd_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (we_bank[b]),
      .waddr(q_item.row),
      .wdata(q_item.kbyte),
      .raddr(raddr),
      .rdata(rk[b])
    );
  end

  // inverse final whitening, byte rotation undone
  always_comb begin
    wf_blk[7] = blk_r[6] ^ rk[3];
    wf_blk[6] = blk_r[5];
    wf_blk[5] = blk_r[4] - rk[2];
    wf_blk[4] = blk_r[3];
    wf_blk[3] = blk_r[2] ^ rk[1];
    wf_blk[2] = blk_r[1];
    wf_blk[1] = blk_r[0] - rk[0];
    wf_blk[0] = blk_r[7];
  end

  // one inverse round with the subkeys of the current row
  always_comb begin
    rnd_blk[0] = blk_r[1];
    rnd_blk[1] = blk_r[2] - (hight_f1(blk_r[1]) ^ rk[0]);
    rnd_blk[2] = blk_r[3];
    rnd_blk[3] = blk_r[4] ^ (hight_f0(blk_r[3]) + rk[1]);
    rnd_blk[4] = blk_r[5];
    rnd_blk[5] = blk_r[6] - (hight_f1(blk_r[5]) ^ rk[2]);
    rnd_blk[6] = blk_r[7];
    rnd_blk[7] = blk_r[0] ^ (hight_f0(blk_r[7]) + rk[3]);
  end

  // inverse initial whitening
  always_comb begin
    wi_blk    = blk_r;
    wi_blk[0] = blk_r[0] - rk[0];
    wi_blk[2] = blk_r[2] ^ rk[1];
    wi_blk[4] = blk_r[4] - rk[2];
    wi_blk[6] = blk_r[6] ^ rk[3];
  end

  // sequencer: read address runs one row ahead of the step that uses it
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pt_nxt    = out_pt_r;
    q_pop         = 1'b0;
    raddr         = ROW_FINAL;
    case (state_r)
      S_IDLE: begin
        raddr = ROW_FINAL;
        if (q_stat.not_empty) begin
          q_pop = 1'b1;
          if (q_item.dec) begin
            blk_nxt   = q_item.text;
            state_nxt = S_WF;
          end
        end
      end
      S_WF: begin
        raddr     = ROW_LAST;
        blk_nxt   = wf_blk;
        rnd_nxt   = ROW_W'(ROUNDS);
        state_nxt = S_RND;
      end
      S_RND: begin
        blk_nxt = rnd_blk;
        if (rnd_r == ROW_W'(1)) begin
          raddr     = ROW_INIT;
          state_nxt = S_WI;
        end else begin
          // round r-1 sits in row r
          raddr   = rnd_r;
          rnd_nxt = rnd_r - ROW_W'(1);
        end
      end
      S_WI: begin
        raddr = ROW_INIT;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pt_nxt    = wi_blk;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r    <= rnd_nxt;
    blk_r    <= blk_nxt;
    out_pt_r <= out_pt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_plaintext  = out_pt_r;
  assign core_stat.busy = (state_r != S_IDLE);
  assign core_stat.last = (state_r == S_WI);

endmodule
